@@ sv/stl_pkg.sv @@
package stl_pkg;

	// Sizing of the scanner
	localparam int NAME_CHARS = 8;
	localparam int VALUE_BITS = 32;
	localparam int LINE_BITS  = 16;

	localparam int NAME_BITS = NAME_CHARS * 8;
	localparam int NCNT_W    = $clog2(NAME_CHARS + 1);

	// Result queue
	localparam int TOK_DEPTH = 8;
	localparam int PTR_W     = $clog2(TOK_DEPTH);
	localparam int QCNT_W    = $clog2(TOK_DEPTH + 1);

	typedef enum logic [4:0] {
		K_FN      = 5'd0,
		K_IF      = 5'd1,
		K_ELSE    = 5'd2,
		K_RETURN  = 5'd3,
		K_NAME    = 5'd4,
		K_TYPE    = 5'd5,
		K_INT     = 5'd6,
		K_FLOAT   = 5'd7,
		K_PLUS    = 5'd8,
		K_MINUS   = 5'd9,
		K_STAR    = 5'd10,
		K_SLASH   = 5'd11,
		K_EQUAL   = 5'd12,
		K_NOTEQ   = 5'd13,
		K_RARROW  = 5'd14,
		K_LARROW  = 5'd15,
		K_NOT     = 5'd16,
		K_LPAREN  = 5'd17,
		K_RPAREN  = 5'd18,
		K_LBRACE  = 5'd19,
		K_RBRACE  = 5'd20,
		K_SET     = 5'd21,
		K_SEMI    = 5'd22,
		K_COMMA   = 5'd23,
		K_END     = 5'd24,
		K_ERROR   = 5'd25
	} kind_t;

	// Keywords packed first character in the low byte
	localparam logic [63:0] KW_FN     = 64'h6e66;
	localparam logic [63:0] KW_IF     = 64'h6669;
	localparam logic [63:0] KW_ELSE   = 64'h6573_6c65;
	localparam logic [63:0] KW_RETURN = 64'h6e72_7574_6572;
	localparam logic [63:0] KW_INT    = 64'h74_6e69;
	localparam logic [63:0] KW_FLOAT  = 64'h74_616f_6c66;

	typedef struct packed {
		kind_t        kind;
		logic [31:0]  number_value;
		logic [3:0]   fraction_digits;
		logic [63:0]  name_text;
		logic [3:0]   name_length;
		logic [15:0]  line_number;
		logic         overflow_flag;
		logic         last_flag;
	} tok_t;

	// Up to two tokens produced by one character
	typedef struct packed {
		logic [1:0] n;
		tok_t       t0;
		tok_t       t1;
	} tok_pair_t;

	typedef struct packed {
		logic  hit;
		kind_t kind;
	} single_t;

	// Operators and punctuation that stand alone
	function automatic single_t single_kind(input logic [7:0] c);
		single_t r;
		r.hit  = 1'b1;
		r.kind = K_ERROR;
		case (c)
			"+": r.kind = K_PLUS;
			"-": r.kind = K_MINUS;
			"*": r.kind = K_STAR;
			"/": r.kind = K_SLASH;
			">": r.kind = K_RARROW;
			"<": r.kind = K_LARROW;
			"(": r.kind = K_LPAREN;
			")": r.kind = K_RPAREN;
			"{": r.kind = K_LBRACE;
			"}": r.kind = K_RBRACE;
			":": r.kind = K_SET;
			";": r.kind = K_SEMI;
			",": r.kind = K_COMMA;
			default: r.hit = 1'b0;
		endcase
		return r;
	endfunction

endpackage

@@ sv/stl_char_if.sv @@
interface stl_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       end_flag;

	modport source (output valid, char_code, end_flag, input ready);
	modport sink (input valid, char_code, end_flag, output ready);
endinterface

@@ sv/stl_token_if.sv @@
interface stl_token_if;
	logic        valid;
	logic        ready;
	logic [4:0]  token_kind;
	logic [31:0] number_value;
	logic [3:0]  fraction_digits;
	logic [63:0] name_text;
	logic [3:0]  name_length;
	logic [15:0] line_number;
	logic        overflow_flag;
	logic        last_flag;

	modport source (output valid, token_kind, number_value, fraction_digits, name_text,
		name_length, line_number, overflow_flag, last_flag, input ready);
	modport sink (input valid, token_kind, number_value, fraction_digits, name_text,
		name_length, line_number, overflow_flag, last_flag, output ready);
endinterface

@@ sv/stl_scan.sv @@
module stl_scan (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              beat,
	input  logic [7:0]        char_code,
	input  logic              end_flag,
	output stl_pkg::tok_pair_t push
);
	import stl_pkg::*;

	typedef enum logic [2:0] {M_IDLE, M_NAME, M_NUM, M_BANG, M_EQ} mode_t;

	localparam int PROD_W = VALUE_BITS + 4;

	// Input register
	logic                 valid_s1;
	logic [7:0]           char_s1;
	logic                 end_s1;

	// Pending token state
	mode_t                mode_q, n_mode;
	logic [NAME_BITS-1:0] buf_q, n_buf;
	logic [NCNT_W-1:0]    ncnt_q, n_ncnt;
	logic [VALUE_BITS-1:0] acc_q, n_acc;
	logic [3:0]           pdig_q, n_pdig;
	logic [1:0]           pseen_q, n_pseen;
	logic                 err_q, n_err;
	logic [LINE_BITS-1:0] line_q, n_line;

	logic                 is_letter, is_digit, is_dot;
	logic                 pair_hit, cont_name, cont_num, do_flush;
	logic                 do_name, do_num;
	logic [3:0]           dig;
	logic [PROD_W-1:0]    prod;
	logic                 mul_ovf;
	single_t              sk;
	tok_t                 blank, fl_tok, ot_tok;
	logic                 fl_emit, ot_emit;
	kind_t                name_kind;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= beat;
		end
	end

	always_ff @(posedge clk) begin
		if (beat) begin
			char_s1 <= char_code;
			end_s1  <= end_flag;
		end
	end

	// Character classes
	assign is_letter = (char_s1 >= "a" && char_s1 <= "z") ||
		(char_s1 >= "A" && char_s1 <= "Z") || char_s1 == "_";
	assign is_digit  = char_s1 >= "0" && char_s1 <= "9";
	assign is_dot    = char_s1 == ".";
	assign dig       = char_s1[3:0];
	assign sk        = single_kind(char_s1);

	// Kind of a finished name
	always_comb begin
		name_kind = K_NAME;
		if (!err_q) begin
			if (64'(buf_q) == KW_FN && ncnt_q == NCNT_W'(2))
				name_kind = K_FN;
			else if (64'(buf_q) == KW_IF && ncnt_q == NCNT_W'(2))
				name_kind = K_IF;
			else if (64'(buf_q) == KW_ELSE && ncnt_q == NCNT_W'(4))
				name_kind = K_ELSE;
			else if (64'(buf_q) == KW_RETURN && ncnt_q == NCNT_W'(6))
				name_kind = K_RETURN;
			else if ((64'(buf_q) == KW_INT && ncnt_q == NCNT_W'(3)) ||
				(64'(buf_q) == KW_FLOAT && ncnt_q == NCNT_W'(5)))
				name_kind = K_TYPE;
		end
	end

	// Token from the pending state
	always_comb begin
		blank             = '0;
		blank.kind        = K_END;
		blank.line_number = 16'(line_q);
		fl_tok  = blank;
		fl_emit = 1'b1;
		case (mode_q)
			M_NAME: begin
				fl_tok.kind          = name_kind;
				fl_tok.name_text     = 64'(buf_q);
				fl_tok.name_length   = 4'(ncnt_q);
				fl_tok.overflow_flag = err_q;
			end
			M_NUM: begin
				fl_tok.kind            = (pseen_q != 2'd0) ? K_FLOAT : K_INT;
				fl_tok.number_value    = 32'(acc_q);
				fl_tok.fraction_digits = (pseen_q != 2'd0) ? pdig_q : 4'd0;
				fl_tok.overflow_flag   = err_q;
			end
			M_BANG: fl_tok.kind = K_NOT;
			M_EQ:   fl_tok.kind = K_ERROR;
			default: fl_emit = 1'b0;
		endcase
	end

	// Next state and tokens for the character in s1
	always_comb begin
		pair_hit  = !end_s1 && char_s1 == "=" && (mode_q == M_BANG || mode_q == M_EQ);
		cont_name = !end_s1 && mode_q == M_NAME && is_letter;
		cont_num  = !end_s1 && mode_q == M_NUM && (is_digit || is_dot);
		do_flush  = !(pair_hit || cont_name || cont_num);

		if (cont_name || cont_num) begin
			n_mode  = mode_q;
			n_buf   = buf_q;
			n_ncnt  = ncnt_q;
			n_acc   = acc_q;
			n_pdig  = pdig_q;
			n_pseen = pseen_q;
			n_err   = err_q;
		end else begin
			n_mode  = M_IDLE;
			n_buf   = '0;
			n_ncnt  = '0;
			n_acc   = '0;
			n_pdig  = '0;
			n_pseen = '0;
			n_err   = 1'b0;
		end
		n_line  = line_q;
		ot_tok  = blank;
		ot_emit = 1'b0;
		do_name = cont_name;
		do_num  = cont_num;

		if (end_s1) begin
			ot_tok.kind = K_END;
			ot_emit     = 1'b1;
		end else if (pair_hit) begin
			ot_tok.kind = (mode_q == M_BANG) ? K_NOTEQ : K_EQUAL;
			ot_emit     = 1'b1;
		end else if (do_flush) begin
			if (char_s1 == 8'h0a) begin
				if (!(&line_q))
					n_line = line_q + 1'b1;
			end else if (is_letter) begin
				n_mode  = M_NAME;
				do_name = 1'b1;
			end else if (is_digit) begin
				n_mode = M_NUM;
				do_num = 1'b1;
			end else if (char_s1 == "!") begin
				n_mode = M_BANG;
			end else if (char_s1 == "=") begin
				n_mode = M_EQ;
			end else if (sk.hit) begin
				ot_tok.kind = sk.kind;
				ot_emit     = 1'b1;
			end
		end

		// Append to a name
		if (do_name) begin
			if (n_ncnt < NCNT_W'(NAME_CHARS)) begin
				for (int i = 0; i < NAME_CHARS; i++)
					if (n_ncnt == NCNT_W'(i))
						n_buf[i*8 +: 8] = char_s1;
				n_ncnt = n_ncnt + 1'b1;
			end else begin
				n_err = 1'b1;
			end
		end

		// Multiply-by-ten accumulate for a number
		prod    = (PROD_W'(n_acc) << 3) + (PROD_W'(n_acc) << 1) + PROD_W'(dig);
		mul_ovf = |prod[PROD_W-1:VALUE_BITS];
		if (do_num) begin
			if (is_dot) begin
				if (n_pseen == 2'd0) begin
					n_pseen = 2'd1;
				end else begin
					n_pseen = 2'd2;
					n_err   = 1'b1;
				end
			end else if (n_pseen == 2'd0) begin
				if (mul_ovf) begin
					n_acc = '1;
					n_err = 1'b1;
				end else if (!n_err) begin
					n_acc = prod[VALUE_BITS-1:0];
				end
			end else if (!n_err) begin
				if (n_pdig == 4'd15 || mul_ovf) begin
					n_err = 1'b1;
				end else begin
					n_acc  = prod[VALUE_BITS-1:0];
					n_pdig = n_pdig + 1'b1;
				end
			end
		end
	end

	// Place tokens in order, flush first
	always_comb begin
		push = '0;
		if (valid_s1) begin
			if (do_flush && fl_emit) begin
				push.t0           = fl_tok;
				push.t0.last_flag = !ot_emit;
				push.t1           = ot_tok;
				push.t1.last_flag = 1'b1;
				push.n            = ot_emit ? 2'd2 : 2'd1;
			end else if (ot_emit) begin
				push.t0           = ot_tok;
				push.t0.last_flag = 1'b1;
				push.n            = 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			buf_q   <= '0;
			ncnt_q  <= '0;
			acc_q   <= '0;
			pdig_q  <= '0;
			pseen_q <= '0;
			err_q   <= 1'b0;
			line_q  <= LINE_BITS'(1);
		end else if (valid_s1) begin
			mode_q  <= n_mode;
			buf_q   <= n_buf;
			ncnt_q  <= n_ncnt;
			acc_q   <= n_acc;
			pdig_q  <= n_pdig;
			pseen_q <= n_pseen;
			err_q   <= n_err;
			line_q  <= n_line;
		end
	end

endmodule

@@ sv/stl_tok_fifo.sv @@
module stl_tok_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  stl_pkg::tok_pair_t  push,
	input  logic                pop,
	output logic                out_valid,
	output stl_pkg::tok_t       out_tok,
	output logic                room
);
	import stl_pkg::*;

	tok_t              mem_q [TOK_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic [PTR_W-1:0]  wr_ptr1;

	assign wr_ptr1   = wr_ptr_q + 1'b1;
	assign out_valid = cnt_q != '0;
	assign out_tok   = mem_q[rd_ptr_q];
	// Space for the beat in s1 and one more beat, two tokens each
	assign room      = cnt_q <= QCNT_W'(TOK_DEPTH - 4);

	always_ff @(posedge clk) begin
		if (push.n != 2'd0)
			mem_q[wr_ptr_q] <= push.t0;
		if (push.n == 2'd2)
			mem_q[wr_ptr1] <= push.t1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.n);
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + QCNT_W'(push.n) - QCNT_W'(pop);
		end
	end

endmodule

@@ sv/source_token_lexer_unit.sv @@
// Source token lexer.
// chars: one source byte per beat (char_code), or end_flag to flush the pending
//   name, number, ! or = and produce an end token. valid/ready handshake.
// tokens: one token per beat, at most two per input beat; last_flag marks the
//   final token caused by an input beat. A beat that causes no token (space,
//   letters inside a name, digits inside a number) produces nothing.
// Path: a token caused by an input beat passes the input register, then the
//   scan logic writes it into the token queue, from which it is presented.
// Throughput: one input beat per cycle while the queue has room; the scanner
//   state and the multiply-by-ten accumulate update together for each beat, so
//   the output beat rate (one token per cycle) is the only limit.
// Stall: tokens collect in an eight-entry queue; chars.ready drops while the
//   queue holds more than four tokens, and resumes as the receiver drains it.
// Reset: arst_n clears the queue, the scanner goes idle with an empty name and
//   number, and the line counter returns to one.
module source_token_lexer_unit (
	input  logic        clk,
	input  logic        arst_n,
	stl_char_if.sink    chars,
	stl_token_if.source tokens
);
	import stl_pkg::*;

	logic      beat;
	logic      room;
	logic      out_valid;
	tok_pair_t push;
	tok_t      out_tok;

	assign chars.ready = room;
	assign beat        = chars.valid & room;

	stl_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.beat      (beat),
		.char_code (chars.char_code),
		.end_flag  (chars.end_flag),
		.push      (push)
	);

	stl_tok_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (out_valid & tokens.ready),
		.out_valid (out_valid),
		.out_tok   (out_tok),
		.room      (room)
	);

	// Output beat fields
	assign tokens.valid           = out_valid;
	assign tokens.token_kind      = out_tok.kind;
	assign tokens.number_value    = out_tok.number_value;
	assign tokens.fraction_digits = out_tok.fraction_digits;
	assign tokens.name_text       = out_tok.name_text;
	assign tokens.name_length     = out_tok.name_length;
	assign tokens.line_number     = out_tok.line_number;
	assign tokens.overflow_flag   = out_tok.overflow_flag;
	assign tokens.last_flag       = out_tok.last_flag;

endmodule

@@ sim/tb_source_token_lexer_unit.sv @@
module tb_source_token_lexer_unit;
	import stl_pkg::*;

	localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;
	localparam logic [LINE_BITS-1:0]  LINE_MAX  = '1;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam int GAP_LONG_MAX = 20;
	localparam int CHAR_TARGET = 1700;
	localparam int DIR_ROWS = 25;

	typedef enum logic [2:0] {
		SCAN_IDLE,
		SCAN_NAME,
		SCAN_NUM,
		SCAN_BANG,
		SCAN_EQ
	} scan_t;

	// Directed row: when fixed is set, the single token it causes is typed in here
	typedef struct packed {
		logic [7:0]  c;
		logic        e;
		logic        fixed;
		kind_t       k;
		logic [15:0] line;
	} dir_row_t;

	logic clk;
	logic arst_n;

	stl_char_if  chars();
	stl_token_if tokens();

	source_token_lexer_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars),
		.tokens (tokens)
	);

	// Lexer shadow state
	scan_t                 scan;
	logic [NAME_BITS-1:0]  word_buf;
	logic [3:0]            word_len;
	logic [VALUE_BITS-1:0] mantissa;
	logic [3:0]            frac_cnt;
	logic [1:0]            point_state;
	logic                  ovf_pend;
	logic [LINE_BITS-1:0]  line_no;

	tok_t step_out[$];
	tok_t tokens_due[$];

	int  chars_sent;
	int  tokens_seen;
	int  mis_count;
	bit  drv_calm;

	// Non-fixed rows carry K_END and line 0 only as filler
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{"+",   1'b0, 1'b1, K_PLUS,  16'd1},
		'{CH_LF, 1'b0, 1'b0, K_END,   16'd0},
		'{"!",   1'b0, 1'b0, K_END,   16'd0},
		'{"=",   1'b0, 1'b1, K_NOTEQ, 16'd2},
		'{"=",   1'b0, 1'b0, K_END,   16'd0},
		'{"=",   1'b0, 1'b1, K_EQUAL, 16'd2},
		'{"=",   1'b0, 1'b0, K_END,   16'd0},
		'{"f",   1'b0, 1'b1, K_ERROR, 16'd2},
		'{"n",   1'b0, 1'b0, K_END,   16'd0},
		'{CH_SP, 1'b0, 1'b0, K_END,   16'd0},
		'{"!",   1'b0, 1'b0, K_END,   16'd0},
		'{"!",   1'b0, 1'b0, K_END,   16'd0},
		'{8'h00, 1'b0, 1'b0, K_END,   16'd0},
		'{8'hFF, 1'b0, 1'b0, K_END,   16'd0},
		'{".",   1'b0, 1'b0, K_END,   16'd0},
		'{"9",   1'b0, 1'b0, K_END,   16'd0},
		'{".",   1'b0, 1'b0, K_END,   16'd0},
		'{"5",   1'b0, 1'b0, K_END,   16'd0},
		'{".",   1'b0, 1'b0, K_END,   16'd0},
		'{"7",   1'b0, 1'b0, K_END,   16'd0},
		'{8'hFF, 1'b1, 1'b0, K_END,   16'd0},
		'{8'h00, 1'b1, 1'b1, K_END,   16'd2},
		'{"-",   1'b0, 1'b1, K_MINUS, 16'd2},
		'{"Z",   1'b0, 1'b0, K_END,   16'd0},
		'{"_",   1'b1, 1'b0, K_END,   16'd0}
	};

	// Clock and reset
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Run limit
	initial begin
		#4000000;
		$display("FAILED: results differ");
		$finish;
	end

	// ---------------- token predictor ----------------

	function automatic bit is_word_char(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic bit is_num(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	// K_ERROR stands for "not a stand-alone character"
	function automatic kind_t op_kind(logic [7:0] c);
		case (c)
			"+": return K_PLUS;
			"-": return K_MINUS;
			"*": return K_STAR;
			"/": return K_SLASH;
			">": return K_RARROW;
			"<": return K_LARROW;
			"(": return K_LPAREN;
			")": return K_RPAREN;
			"{": return K_LBRACE;
			"}": return K_RBRACE;
			":": return K_SET;
			";": return K_SEMI;
			",": return K_COMMA;
			default: return K_ERROR;
		endcase
	endfunction

	function void put_token(kind_t k, logic [31:0] v, logic [3:0] f, logic [63:0] txt,
		logic [3:0] len, logic ovf);
		tok_t t;
		if (step_out.size() < 2) begin
			t.kind            = k;
			t.number_value    = v;
			t.fraction_digits = f;
			t.name_text       = txt;
			t.name_length     = len;
			t.line_number     = line_no;
			t.overflow_flag   = ovf;
			t.last_flag       = 1'b0;
			step_out.push_back(t);
		end
	endfunction

	function void clear_word();
		scan        = SCAN_IDLE;
		word_buf    = '0;
		word_len    = '0;
		mantissa    = '0;
		frac_cnt    = '0;
		point_state = '0;
		ovf_pend    = 1'b0;
	endfunction

	// Emit whatever token is being collected, then go idle
	function void flush_word();
		kind_t k;
		case (scan)
			SCAN_NAME: begin
				k = K_NAME;
				if (!ovf_pend) begin
					if (word_len == 2 && word_buf == KW_FN) k = K_FN;
					if (word_len == 2 && word_buf == KW_IF) k = K_IF;
					if (word_len == 4 && word_buf == KW_ELSE) k = K_ELSE;
					if (word_len == 6 && word_buf == KW_RETURN) k = K_RETURN;
					if (word_len == 3 && word_buf == KW_INT) k = K_TYPE;
					if (word_len == 5 && word_buf == KW_FLOAT) k = K_TYPE;
				end
				put_token(k, '0, '0, word_buf, word_len, ovf_pend);
			end
			SCAN_NUM: begin
				if (point_state != 0)
					put_token(K_FLOAT, mantissa, frac_cnt, '0, '0, ovf_pend);
				else
					put_token(K_INT, mantissa, '0, '0, '0, ovf_pend);
			end
			SCAN_BANG: put_token(K_NOT, '0, '0, '0, '0, 1'b0);
			SCAN_EQ:   put_token(K_ERROR, '0, '0, '0, '0, 1'b0);
			default: ;
		endcase
		clear_word();
	endfunction

	// Decimal accumulate with saturation; a second point freezes the value
	function void number_digit(logic [7:0] c);
		longint unsigned d;
		longint unsigned lim;
		if (c == ".") begin
			if (point_state == 0) begin
				point_state = 1;
			end else begin
				point_state = 2;
				ovf_pend    = 1'b1;
			end
			return;
		end
		d   = longint'(c) - 48;
		lim = (longint'(VALUE_MAX) - d) / 10;
		if (point_state == 0) begin
			if (mantissa > lim) begin
				mantissa = VALUE_MAX;
				ovf_pend = 1'b1;
			end else if (!ovf_pend) begin
				mantissa = mantissa * 10 + d;
			end
		end else if (!ovf_pend) begin
			if (frac_cnt >= 15 || mantissa > lim) begin
				ovf_pend = 1'b1;
			end else begin
				mantissa = mantissa * 10 + d;
				frac_cnt++;
			end
		end
	endfunction

	function void name_letter(logic [7:0] c);
		if (word_len < NAME_CHARS) begin
			word_buf[8*word_len +: 8] = c;
			word_len++;
		end else begin
			ovf_pend = 1'b1;
		end
	endfunction

	function void idle_byte(logic [7:0] c);
		kind_t k;
		k = op_kind(c);
		if (c == CH_LF) begin
			if (line_no != LINE_MAX) line_no++;
		end else if (is_word_char(c)) begin
			scan = SCAN_NAME;
			name_letter(c);
		end else if (is_num(c)) begin
			scan = SCAN_NUM;
			number_digit(c);
		end else if (c == "!") begin
			scan = SCAN_BANG;
		end else if (c == "=") begin
			scan = SCAN_EQ;
		end else if (k != K_ERROR) begin
			put_token(k, '0, '0, '0, '0, 1'b0);
		end
	endfunction

	// Tokens caused by one accepted char beat, left in step_out
	function void lex_step(logic [7:0] c, logic e);
		tok_t t;
		step_out.delete();
		if (e) begin
			flush_word();
			put_token(K_END, '0, '0, '0, '0, 1'b0);
		end else if (scan == SCAN_BANG && c == "=") begin
			put_token(K_NOTEQ, '0, '0, '0, '0, 1'b0);
			clear_word();
		end else if (scan == SCAN_EQ && c == "=") begin
			put_token(K_EQUAL, '0, '0, '0, '0, 1'b0);
			clear_word();
		end else if (scan == SCAN_NAME && is_word_char(c)) begin
			name_letter(c);
		end else if (scan == SCAN_NUM && (is_num(c) || c == ".")) begin
			number_digit(c);
		end else begin
			flush_word();
			idle_byte(c);
		end
		if (step_out.size() > 0) begin
			t = step_out.pop_back();
			t.last_flag = 1'b1;
			step_out.push_back(t);
		end
	endfunction

	// ---------------- char side ----------------

	function automatic int pick_gap();
		int r;
		if (drv_calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(4, GAP_LONG_MAX);
	endfunction

	// One char beat; prediction is made at the accepting edge
	task automatic send(logic [7:0] c, logic e, logic fixed, kind_t k, logic [15:0] line);
		int   gap;
		tok_t t;
		gap = pick_gap();
		if (gap > 0) begin
			chars.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		chars.valid     <= 1'b1;
		chars.char_code <= c;
		chars.end_flag  <= e;
		@(posedge clk);
		while (chars.ready !== 1'b1) @(posedge clk);
		lex_step(c, e);
		if (fixed) begin
			t = '0;
			t.kind        = k;
			t.line_number = line;
			t.last_flag   = 1'b1;
			tokens_due.push_back(t);
		end else begin
			foreach (step_out[i]) tokens_due.push_back(step_out[i]);
		end
		chars_sent++;
	endtask

	task automatic send_char(logic [7:0] c);
		send(c, 1'b0, 1'b0, K_END, '0);
	endtask

	task automatic send_text(string s);
		int i;
		for (i = 0; i < s.len(); i++) send_char(s[i]);
	endtask

	task automatic send_digits(int n);
		int i;
		for (i = 0; i < n; i++) send_char(8'($urandom_range(48, 57)));
	endtask

	function automatic logic [7:0] rand_letter();
		int r;
		r = $urandom_range(0, 52);
		if (r < 26) return 8'(97 + r);
		if (r < 52) return 8'(65 + r - 26);
		return "_";
	endfunction

	// Numbers: near and past saturation, long fractions, second points
	task automatic send_number();
		int m;
		m = $urandom_range(0, 9);
		case (m)
			0: send_text("4294967295");
			1: send_text("4294967296");
			2: send_text($sformatf("%0d", $urandom));
			3: send_digits($urandom_range(11, 14));
			default: send_digits($urandom_range(1, 4));
		endcase
		if ($urandom_range(0, 1) == 1) begin
			send_char(".");
			if ($urandom_range(0, 4) == 0)
				send_digits($urandom_range(10, 18));
			else
				send_digits($urandom_range(0, 5));
			if ($urandom_range(0, 6) == 0) begin
				send_char(".");
				send_digits($urandom_range(0, 3));
			end
		end
	endtask

	// One random piece of source text
	task automatic send_piece();
		string kw [6];
		string s;
		string ops;
		string pairs [4];
		int    r;
		int    n;
		int    i;
		kw    = '{"fn", "if", "else", "return", "int", "float"};
		pairs = '{"!=", "==", "!", "="};
		ops   = "+-*/<>(){}:;,";
		r = $urandom_range(0, 99);
		if (r < 18) begin
			// keywords, types and near misses
			s = kw[$urandom_range(0, 5)];
			if ($urandom_range(0, 5) == 0) s = s.substr(0, s.len() - 2);
			send_text(s);
			if ($urandom_range(0, 4) == 0) send_char(rand_letter());
		end else if (r < 35) begin
			n = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 8);
			for (i = 0; i < n; i++) send_char(rand_letter());
		end else if (r < 58) begin
			send_number();
		end else if (r < 75) begin
			send_char(ops[$urandom_range(0, ops.len() - 1)]);
		end else if (r < 83) begin
			send_text(pairs[$urandom_range(0, 3)]);
		end else if (r < 96) begin
			n = $urandom_range(0, 2);
			if (n == 0) send_char(CH_SP);
			else if (n == 1) send_char(CH_LF);
			else send_char(8'($urandom_range(0, 255)));
		end else begin
			send(8'($urandom_range(0, 255)), 1'b1, 1'b0, K_END, '0);
		end
		if ($urandom_range(0, 9) < 6) send_char(($urandom_range(0, 3) == 0) ? CH_LF : CH_SP);
	endtask

	task automatic random_until(int target);
		while (chars_sent < target) begin
			if ($urandom_range(0, drv_calm ? 30 : 60) == 0) drv_calm = !drv_calm;
			send_piece();
		end
	endtask

	// Main stimulus
	initial begin
		int i;
		chars.valid     <= 1'b0;
		chars.char_code <= '0;
		chars.end_flag  <= 1'b0;
		chars_sent = 0;
		drv_calm   = 1'b0;
		clear_word();
		line_no = 1;
		wait (arst_n === 1'b1);
		@(posedge clk);

		for (i = 0; i < DIR_ROWS; i++)
			send(dir_rows[i].c, dir_rows[i].e, dir_rows[i].fixed, dir_rows[i].k,
				dir_rows[i].line);

		random_until(CHAR_TARGET);
		chars.valid <= 1'b0;

		while (tokens_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Covered %0d char beats of mixed source text; %0d tokens checked.",
			chars_sent, tokens_seen);
		$display("Mismatching tokens: %0d", mis_count);
		if (mis_count == 0 && tokens_due.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// ---------------- token side ----------------

	// Receiver stalls: mostly short, some long, with calm stretches
	initial begin
		int stall;
		bit calm;
		stall = 0;
		calm  = 1'b0;
		tokens.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if ($urandom_range(0, calm ? 40 : 80) == 0) calm = !calm;
			if (stall > 0) begin
				tokens.ready <= 1'b0;
				stall--;
			end else if (calm || $urandom_range(0, 99) < 70) begin
				tokens.ready <= 1'b1;
			end else begin
				tokens.ready <= 1'b0;
				stall = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 30) : $urandom_range(0, 2);
			end
		end
	end

	// Compare every token beat with the oldest prediction
	initial begin
		tokens_seen = 0;
		mis_count   = 0;
	end

	always @(posedge clk) begin
		tok_t got;
		tok_t want;
		if (arst_n === 1'b1 && tokens.valid === 1'b1 && tokens.ready === 1'b1) begin
			got.kind            = kind_t'(tokens.token_kind);
			got.number_value    = tokens.number_value;
			got.fraction_digits = tokens.fraction_digits;
			got.name_text       = tokens.name_text;
			got.name_length     = tokens.name_length;
			got.line_number     = tokens.line_number;
			got.overflow_flag   = tokens.overflow_flag;
			got.last_flag       = tokens.last_flag;
			tokens_seen++;
			if (tokens_due.size() == 0) begin
				mis_count++;
				if (mis_count <= 10)
					$display("token %0d not expected: kind=%0d line=%0d", tokens_seen,
						got.kind, got.line_number);
			end else begin
				want = tokens_due.pop_front();
				if (got.kind !== want.kind || got.number_value !== want.number_value ||
					got.fraction_digits !== want.fraction_digits ||
					got.name_text !== want.name_text || got.name_length !== want.name_length ||
					got.line_number !== want.line_number ||
					got.overflow_flag !== want.overflow_flag ||
					got.last_flag !== want.last_flag) begin
					mis_count++;
					if (mis_count <= 10) begin
						$display("token %0d exp: kind=%0d val=%0d frac=%0d text=%h len=%0d",
							tokens_seen, want.kind, want.number_value, want.fraction_digits,
							want.name_text, want.name_length);
						$display("  exp line=%0d ovf=%b last=%b", want.line_number,
							want.overflow_flag, want.last_flag);
						$display("  got: kind=%0d val=%0d frac=%0d text=%h len=%0d",
							got.kind, got.number_value, got.fraction_digits, got.name_text,
							got.name_length);
						$display("  got line=%0d ovf=%b last=%b", got.line_number,
							got.overflow_flag, got.last_flag);
					end
				end
			end
		end
	end

endmodule
